### hdl/avm_pkg.sv
`timescale 1ns / 1ps

package avm_pkg;

    // Default sample width of one acceleration axis.
    localparam int SAMPLE_WIDTH_DEF = 19;

    // Default number of entries between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Gravity reference register.
    localparam int GRAVITY_W = 18;
    localparam logic [GRAVITY_W-1:0] GRAVITY_RESET = 18'd9807;

    // Status that the queue reports to the front and the back.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage

### hdl/accel_vector_magnitude_core.sv
`timescale 1ns / 1ps

// Acceleration vector magnitude core. Each beat on the input carries one
// three-axis sample; each beat on the output carries the echoed axes, the
// floor square root of the sum of squares, that root minus the gravity
// reference, and the floor root of the squared change to the previous
// sample (zero for the first sample after reset). A single shared squarer
// and a bit-serial square root set the rate: each root follows a squaring
// pass over the three axes, and the first sample after reset skips the
// change root. A small queue at the input lets new samples be accepted
// while the back is busy, and a finished result waits in the output
// register without holding up the next computation.
// Write the gravity reference only while the core is idle.
module accel_vector_magnitude_core #(
    parameter int SAMPLE_WIDTH = avm_pkg::SAMPLE_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = avm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [avm_pkg::GRAVITY_W-1:0]  i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_echo_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_echo_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_echo_z,
    output logic [SAMPLE_WIDTH-1:0]        o_norm_magnitude,
    output logic signed [SAMPLE_WIDTH:0]   o_gravity_error,
    output logic [SAMPLE_WIDTH:0]          o_change_magnitude
);
    import avm_pkg::*;

    localparam int ENTRY_W = 6 * SAMPLE_WIDTH + 4;

    logic [GRAVITY_W-1:0] r_gravity;
    logic                 q_push;
    logic                 q_pop;
    logic [ENTRY_W-1:0]   q_wr_data;
    logic [ENTRY_W-1:0]   q_rd_data;
    t_queue_status        q_status;

    // Gravity reference register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            r_gravity <= i_cfg_data;
        end
    end

    avm_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_entry    (q_wr_data)
    );

    avm_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wr_data),
        .i_pop    (q_pop),
        .o_data   (q_rd_data),
        .o_status (q_status)
    );

    avm_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_status.not_empty),
        .i_entry            (q_rd_data),
        .o_pop              (q_pop),
        .i_gravity          (r_gravity),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_echo_x           (o_echo_x),
        .o_echo_y           (o_echo_y),
        .o_echo_z           (o_echo_z),
        .o_norm_magnitude   (o_norm_magnitude),
        .o_gravity_error    (o_gravity_error),
        .o_change_magnitude (o_change_magnitude)
    );

    // The front never writes a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("queue written while full");

    // The back never reads an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_status.not_empty)
        else $error("queue read while empty");

    // A result is never offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

endmodule

### hdl/avm_queue.sv
`timescale 1ns / 1ps

module avm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_data,
    output avm_pkg::t_queue_status o_status
);
    import avm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // Pointers wrap at the depth, which need not be a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data             = r_mem[r_rd_ptr];
    assign o_status.full      = (r_count == CNT_W'(DEPTH));
    assign o_status.not_empty = (r_count != '0);

endmodule

### hdl/avm_front.sv
`timescale 1ns / 1ps

module avm_front #(
    parameter int SAMPLE_WIDTH = avm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0] i_accel_z,
    input  avm_pkg::t_queue_status        i_q_status,
    output logic                          o_push,
    output logic [6*SAMPLE_WIDTH+3:0]     o_entry
);
    import avm_pkg::*;

    localparam int W = SAMPLE_WIDTH;

    logic         r_prev_held;
    logic [W-1:0] r_prev_x;
    logic [W-1:0] r_prev_y;
    logic [W-1:0] r_prev_z;
    logic [W:0]   w_dx;
    logic [W:0]   w_dy;
    logic [W:0]   w_dz;

    // A beat is taken whenever the queue has room.
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    // Differences to the previous sample, one bit wider than an axis.
    assign w_dx = {i_accel_x[W-1], i_accel_x} - {r_prev_x[W-1], r_prev_x};
    assign w_dy = {i_accel_y[W-1], i_accel_y} - {r_prev_y[W-1], r_prev_y};
    assign w_dz = {i_accel_z[W-1], i_accel_z} - {r_prev_z[W-1], r_prev_z};

    // The flag tells the back whether the change root is needed at all.
    assign o_entry = {r_prev_held, i_accel_x, i_accel_y, i_accel_z, w_dx, w_dy, w_dz};

    // Every accepted sample becomes the previous one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_held <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
        end else if (o_push) begin
            r_prev_held <= 1'b1;
            r_prev_x    <= i_accel_x;
            r_prev_y    <= i_accel_y;
            r_prev_z    <= i_accel_z;
        end
    end

endmodule

### hdl/avm_back.sv
`timescale 1ns / 1ps

module avm_back #(
    parameter int SAMPLE_WIDTH = avm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  logic [6*SAMPLE_WIDTH+3:0]      i_entry,
    output logic                           o_pop,
    input  logic [avm_pkg::GRAVITY_W-1:0]  i_gravity,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_echo_x,
    output logic signed [SAMPLE_WIDTH-1:0] o_echo_y,
    output logic signed [SAMPLE_WIDTH-1:0] o_echo_z,
    output logic [SAMPLE_WIDTH-1:0]        o_norm_magnitude,
    output logic signed [SAMPLE_WIDTH:0]   o_gravity_error,
    output logic [SAMPLE_WIDTH:0]          o_change_magnitude
);
    import avm_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int RAW_W = 2 * W + 2;
    localparam int SQ_W  = (RAW_W > 64) ? 64 : RAW_W;
    localparam int EXT_W = (W + 1 > GRAVITY_W) ? W + 1 : GRAVITY_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_phase;
    logic [1:0]          r_axis;
    logic [6*W+3:0]      r_entry;
    logic [RAW_W-1:0]    r_prod;
    logic [RAW_W-1:0]    r_acc;
    logic [SQ_W-1:0]     r_rem;
    logic [SQ_W-1:0]     r_root;
    logic [SQ_W-1:0]     r_bit;
    logic [W-1:0]        r_norm;
    logic [W:0]          r_change;
    logic                r_out_valid;

    logic                w_prev_held;
    logic [W-1:0]        w_x;
    logic [W-1:0]        w_y;
    logic [W-1:0]        w_z;
    logic [W:0]          w_dx;
    logic [W:0]          w_dy;
    logic [W:0]          w_dz;
    logic signed [W:0]   w_op;
    logic signed [RAW_W-1:0] w_prod;
    logic [RAW_W-1:0]    w_sum;
    logic                w_sat;
    logic [SQ_W:0]       w_trial;
    logic                w_take;
    logic [SQ_W-1:0]     w_rem_next;
    logic [SQ_W-1:0]     w_root_next;
    logic [EXT_W-1:0]    w_err_full;
    logic                w_load;

    assign {w_prev_held, w_x, w_y, w_z, w_dx, w_dy, w_dz} = r_entry;

    // One shared squarer: the axis in the first phase, the difference in the second.
    always_comb begin
        case (r_axis)
            2'd0:    w_op = r_phase ? w_dx : {w_x[W-1], w_x};
            2'd1:    w_op = r_phase ? w_dy : {w_y[W-1], w_y};
            default: w_op = r_phase ? w_dz : {w_z[W-1], w_z};
        endcase
    end

    assign w_prod = w_op * w_op;

    // Last sum of squares, clamped to the root's input width when it overflows.
    assign w_sum = r_acc + r_prod;
    assign w_sat = |(w_sum >> SQ_W);

    // One root bit per cycle, restoring form.
    assign w_trial = {1'b0, r_root} + {1'b0, r_bit};
    assign w_take  = ({1'b0, r_rem} >= w_trial);

    always_comb begin
        if (w_take) begin
            w_rem_next  = r_rem - w_trial[SQ_W-1:0];
            w_root_next = (r_root >> 1) + r_bit;
        end else begin
            w_rem_next  = r_rem;
            w_root_next = r_root >> 1;
        end
    end

    // Gravity error wraps to the output width.
    assign w_err_full = EXT_W'(r_norm) - EXT_W'(i_gravity);

    // The output register takes a finished result once it is free or being drained.
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_out_valid;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_entry <= i_entry;
                        r_phase <= 1'b0;
                        r_axis  <= '0;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_prod <= RAW_W'(unsigned'(w_prod));
                    if (r_axis == 2'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= w_sum;
                    end
                    if (r_axis == 2'd3) begin
                        r_rem   <= w_sat ? '1 : w_sum[SQ_W-1:0];
                        r_root  <= '0;
                        r_bit   <= {2'b01, {(SQ_W-2){1'b0}}};
                        r_state <= S_ROOT;
                    end
                    r_axis <= r_axis + 1'b1;
                end
                S_ROOT: begin
                    r_rem  <= w_rem_next;
                    r_root <= w_root_next;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        if (!r_phase) begin
                            r_norm <= w_root_next[W-1:0];
                            if (w_prev_held) begin
                                r_phase <= 1'b1;
                                r_axis  <= '0;
                                r_state <= S_SQUARE;
                            end else begin
                                r_change <= '0;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_change <= w_root_next[W:0];
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        o_echo_x           <= w_x;
                        o_echo_y           <= w_y;
                        o_echo_z           <= w_z;
                        o_norm_magnitude   <= r_norm;
                        o_gravity_error    <= w_err_full[W:0];
                        o_change_magnitude <= r_change;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SW = avm_pkg::SAMPLE_WIDTH_DEF;
    localparam int GW = avm_pkg::GRAVITY_W;
    localparam logic signed [SW-1:0] AXIS_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] AXIS_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [GW-1:0] GRAVITY_MAX = {GW{1'b1}};
    localparam int RANDOM_PER_PHASE = 310;
    localparam int NUM_PHASES = 5;
    localparam int QUIET_PHASE = 2;
    localparam int IDLE_PCT = 37;
    localparam int SETTLE_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 1000000;

    // One output beat, field by field.
    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
        logic [SW-1:0]        norm;
        logic signed [SW:0]   grav_err;
        logic [SW:0]          change;
    } t_accel_result;

    // Predicts the magnitude results of each accepted sample and checks the
    // output beats against them in order.
    class accel_scoreboard;
        logic [GW-1:0]        gravity;
        bit                   prev_held;
        logic signed [SW-1:0] prev_x;
        logic signed [SW-1:0] prev_y;
        logic signed [SW-1:0] prev_z;
        t_accel_result        pending[$];
        int                   errors;

        function new();
            gravity   = avm_pkg::GRAVITY_RESET;
            prev_held = 1'b0;
            prev_x    = '0;
            prev_y    = '0;
            prev_z    = '0;
            errors    = 0;
        endfunction

        // Largest r with r*r <= v, built one root bit at a time from the top.
        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= v) begin
                    r = trial;
                end
            end
            return r;
        endfunction

        function longint unsigned sum_sq(longint a, longint b, longint c);
            return longint'(a * a + b * b + c * c);
        endfunction

        function void note_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                                  logic signed [SW-1:0] z);
            t_accel_result   res;
            longint unsigned norm;
            longint unsigned change;
            norm   = floor_root(sum_sq(longint'(x), longint'(y), longint'(z)));
            change = 0;
            if (prev_held) begin
                change = floor_root(sum_sq(longint'(x) - longint'(prev_x),
                                           longint'(y) - longint'(prev_y),
                                           longint'(z) - longint'(prev_z)));
            end
            res.x        = x;
            res.y        = y;
            res.z        = z;
            res.norm     = norm[SW-1:0];
            res.grav_err = (SW+1)'(norm - longint'(gravity));
            res.change   = change[SW:0];
            pending.push_back(res);
            // The sample just taken is the reference for the next change.
            prev_held = 1'b1;
            prev_x    = x;
            prev_y    = y;
            prev_z    = z;
        endfunction

        function void report(string what, t_accel_result want, t_accel_result got);
            errors++;
            if (errors <= 10) begin
                $display("%s: expected x=%0d y=%0d z=%0d norm=%0d gerr=%0d chg=%0d",
                         what, want.x, want.y, want.z, want.norm, want.grav_err,
                         want.change);
                $display("      actual x=%0d y=%0d z=%0d norm=%0d gerr=%0d chg=%0d",
                         got.x, got.y, got.z, got.norm, got.grav_err, got.change);
            end
        endfunction

        function void check_result(t_accel_result got);
            t_accel_result want;
            if (pending.size() == 0) begin
                report("Unexpected beat", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                got.norm !== want.norm || got.grav_err !== want.grav_err ||
                got.change !== want.change) begin
                report("Mismatch", want, got);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [GW-1:0]         i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic signed [SW-1:0]  i_accel_x = '0;
    logic signed [SW-1:0]  i_accel_y = '0;
    logic signed [SW-1:0]  i_accel_z = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [SW-1:0]  o_echo_x;
    logic signed [SW-1:0]  o_echo_y;
    logic signed [SW-1:0]  o_echo_z;
    logic [SW-1:0]         o_norm_magnitude;
    logic signed [SW:0]    o_gravity_error;
    logic [SW:0]           o_change_magnitude;

    logic                  quiet_mode = 1'b0;
    longint                cycle_count = 0;
    logic signed [SW-1:0]  last_x = '0;
    logic signed [SW-1:0]  last_y = '0;
    logic signed [SW-1:0]  last_z = '0;
    accel_scoreboard       sb = new();

    accel_vector_magnitude_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_accel_x          (i_accel_x),
        .i_accel_y          (i_accel_y),
        .i_accel_z          (i_accel_z),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_echo_x           (o_echo_x),
        .o_echo_y           (o_echo_y),
        .o_echo_z           (o_echo_z),
        .o_norm_magnitude   (o_norm_magnitude),
        .o_gravity_error    (o_gravity_error),
        .o_change_magnitude (o_change_magnitude)
    );

    // Clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Output side stalls at random except in the quiet phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Every accepted output beat goes to the scoreboard.
    always @(posedge i_clk) begin
        t_accel_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.x        = o_echo_x;
            got.y        = o_echo_y;
            got.z        = o_echo_z;
            got.norm     = o_norm_magnitude;
            got.grav_err = o_gravity_error;
            got.change   = o_change_magnitude;
            sb.check_result(got);
        end
    end

    // Offers one sample, after an optional random gap, and returns on the
    // edge that accepts it with valid still high.
    task automatic send_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                               logic signed [SW-1:0] z);
        int gap;
        gap = 0;
        if (!quiet_mode) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                gap++;
            end
            if ($urandom_range(19) == 0) begin
                gap += $urandom_range(60, 1);
            end
        end
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        do begin
            @(posedge i_clk);
        end while (!(i_valid && o_ready));
        sb.note_sample(x, y, z);
        last_x = x;
        last_y = y;
        last_z = z;
    endtask

    // Lowers valid and waits until every expected beat is back.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_gravity(logic [GW-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.gravity = value;
    endtask

    // One axis value: full range, within +-12000, near the last value, tiny, or an extreme.
    function automatic logic signed [SW-1:0] pick_axis(logic signed [SW-1:0] last);
        int sel;
        logic signed [SW-1:0] v;
        sel = $urandom_range(19);
        if (sel < 7) begin
            v = SW'($urandom);
        end else if (sel < 11) begin
            v = SW'($signed($urandom_range(24000)) - 12000);
        end else if (sel < 14) begin
            v = SW'(int'(last) + ($signed($urandom_range(64)) - 32));
        end else if (sel < 17) begin
            v = SW'($signed($urandom_range(32)) - 16);
        end else begin
            case ($urandom_range(3))
                0: v = AXIS_MAX;
                1: v = AXIS_MIN;
                2: v = '1;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    initial begin
        int            dx[$];
        int            dy[$];
        int            dz[$];
        logic [GW-1:0] grav;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples at the reset gravity: zero first, perfect squares,
        // axis extremes, the largest change and a repeated sample.
        dx = '{0, 9807, 0, 3000, int'(AXIS_MAX), int'(AXIS_MIN), int'(AXIS_MAX),
               int'(AXIS_MIN), 0, 0, int'(AXIS_MAX), -1, 1, 1, 0, 0, -5, 9806,
               int'(19'sh2AAAA), int'(19'sh55555)};
        dy = '{0, 0, -9807, 4000, int'(AXIS_MAX), int'(AXIS_MIN), int'(AXIS_MAX), 0,
               int'(AXIS_MIN), 0, int'(AXIS_MIN), -1, 1, 0, 0, 0, -12, 1,
               int'(19'sh55555), int'(19'sh2AAAA)};
        dz = '{0, 0, 0, 0, int'(AXIS_MAX), int'(AXIS_MIN), int'(AXIS_MAX), 0, 0,
               int'(AXIS_MIN), int'(AXIS_MAX), -1, 1, 0, 0, 0, 84, 0,
               int'(19'sh2AAAA), int'(19'sh55555)};
        foreach (dx[i]) begin
            send_sample(SW'(dx[i]), SW'(dy[i]), SW'(dz[i]));
        end
        drain();

        // Random phases, each under a different gravity reference.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: grav = '0;
                1: grav = GRAVITY_MAX;
                3: grav = avm_pkg::GRAVITY_RESET;
                default: grav = GW'($urandom);
            endcase
            write_gravity(grav);
            quiet_mode <= (ph == QUIET_PHASE);
            @(posedge i_clk);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_sample(pick_axis(last_x), pick_axis(last_y), pick_axis(last_z));
            end
            drain();
        end

        // Anything still expected never came out.
        sb.errors += sb.pending.size();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
